>>> hdl/pqra_pkg.sv
// Shared constants for the page quota reserve accountant.
package pqra_pkg;

    // Width of every count field on the item channels and the configuration port.
    localparam int FIELD_BITS = 32;

    // Default width of the internal page counters.
    localparam int DEFAULT_COUNT_BITS = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_LIMIT_ON   = 2'd0;
    localparam t_cfg_idx CFG_MAX_PAGES      = 2'd1;
    localparam t_cfg_idx CFG_MIN_RESERVE_ON = 2'd2;
    localparam t_cfg_idx CFG_MIN_PAGES      = 2'd3;

    // Request action codes.
    localparam logic ACT_TAKE   = 1'b0;
    localparam logic ACT_RETURN = 1'b1;

    // Result status codes.
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

endpackage

>>> hdl/pqra_req_if.sv
// Request channel: one take or return of pages per item.
interface pqra_req_if
    import pqra_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [FIELD_BITS-1:0] page_count;

    modport source (output valid, output action, output page_count, input ready);
    modport sink   (input valid, input action, input page_count, output ready);
endinterface

>>> hdl/pqra_rsp_if.sv
// Result channel: status, charge and counter values after each item.
interface pqra_rsp_if
    import pqra_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [FIELD_BITS-1:0] pages_to_charge;
    logic [FIELD_BITS-1:0] used_now;
    logic [FIELD_BITS-1:0] reserve_now;

    modport source (output valid, output status, output pages_to_charge,
                    output used_now, output reserve_now, input ready);
    modport sink   (input valid, input status, input pages_to_charge,
                    input used_now, input reserve_now, output ready);
endinterface

>>> hdl/page_quota_reserve_accounting.sv
// Pool page quota accountant with maximum limit and minimum reserve.
//
// Usage: each item on i_req takes (action 0) or returns (action 1) a number
// of pages. For every item exactly one result leaves on o_rsp, in order,
// carrying the status, the pages still to be charged globally, and the used
// and reserve counts after the item.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle. Writing min_pages clears the used count and loads the
// reserve with the new minimum.
// Timing: an accepted item enters the input register, and its result enters
// the output register as soon as that register is free or being taken.
// Throughput is one item per cycle while the receiver takes every result; the
// counters are written by the accounting logic together with the output register.
// Reset (synchronous, i_rst_n low) clears the configuration registers, both
// counters and both valid flags; the payload registers are not reset. When
// the receiver stalls, the result holds in the output register, one more item
// can sit in the input register, and then i_req.ready drops until the
// receiver takes the result.
module page_quota_reserve_accounting
    import pqra_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [FIELD_BITS-1:0] i_cfg_data,
    pqra_req_if.sink              i_req,
    pqra_rsp_if.source            o_rsp
);

    localparam int W  = COUNT_BITS;
    localparam int WX = (W > FIELD_BITS) ? W : FIELD_BITS;

    localparam logic [W-1:0]  CNT_MAX   = {W{1'b1}};
    localparam logic [WX-1:0] CNT_MAX_X = WX'(CNT_MAX);

    // Configuration registers and counters.
    logic         r_lim_on;
    logic [W-1:0] r_max;
    logic         r_res_on;
    logic [W-1:0] r_min;
    logic [W-1:0] r_used;
    logic [W-1:0] r_reserve;

    // Input register.
    logic         r_s1_valid;
    logic         r_s1_action;
    logic [W-1:0] r_s1_delta;

    // Output register.
    logic                  r_out_valid;
    logic                  r_status;
    logic [FIELD_BITS-1:0] r_charge;
    logic [FIELD_BITS-1:0] r_used_out;
    logic [FIELD_BITS-1:0] r_res_out;

    // Next values from the accounting logic.
    logic         n_status;
    logic [W-1:0] n_charge;
    logic [W-1:0] n_used;
    logic [W-1:0] n_reserve;

    logic         advance;
    logic [WX-1:0] req_x;
    logic [WX-1:0] cfg_x;
    logic [W-1:0]  req_delta;
    logic [W-1:0]  cfg_val;

    // Working values of the accounting logic.
    logic [W:0]   take_sum;
    logic [W-1:0] ret_used;
    logic [W-1:0] limit;
    logic [W-1:0] excess;
    logic [W:0]   excess_sum;
    logic         over;

    // Handshake: the input register moves whenever the output register is free.
    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || advance;

    // Saturate incoming 32-bit values to the counter range.
    assign req_x     = WX'(i_req.page_count);
    assign cfg_x     = WX'(i_cfg_data);
    assign req_delta = (req_x > CNT_MAX_X) ? CNT_MAX : W'(req_x);
    assign cfg_val   = (cfg_x > CNT_MAX_X) ? CNT_MAX : W'(cfg_x);

    // Accounting for one item.
    always_comb begin
        take_sum   = {1'b0, r_used} + {1'b0, r_s1_delta};
        ret_used   = (r_s1_delta > r_used) ? '0 : r_used - r_s1_delta;
        limit      = r_min - ret_used;
        excess     = r_reserve - limit;
        excess_sum = {1'b0, excess} + {1'b0, r_s1_delta};
        over       = r_lim_on &&
                     (r_used > r_max || r_s1_delta > r_max - r_used);

        n_status  = STAT_DONE;
        n_charge  = r_s1_delta;
        n_used    = r_used;
        n_reserve = r_reserve;

        if (r_s1_action == ACT_TAKE) begin
            if (over) begin
                n_status = STAT_REFUSED;
                n_charge = '0;
            end else begin
                n_used = take_sum[W] ? CNT_MAX : take_sum[W-1:0];
                if (r_res_on && r_reserve != '0) begin
                    if (r_s1_delta > r_reserve) begin
                        n_charge  = r_s1_delta - r_reserve;
                        n_reserve = '0;
                    end else begin
                        n_charge  = '0;
                        n_reserve = r_reserve - r_s1_delta;
                    end
                end
            end
        end else begin
            n_used = ret_used;
            if (r_res_on && ret_used < r_min) begin
                if (r_reserve <= limit && r_s1_delta <= limit - r_reserve) begin
                    // The reserve absorbs the whole return.
                    n_charge  = '0;
                    n_reserve = r_reserve + r_s1_delta;
                end else begin
                    if (r_reserve >= limit) begin
                        n_charge = excess_sum[W] ? CNT_MAX : excess_sum[W-1:0];
                    end else begin
                        n_charge = r_s1_delta - (limit - r_reserve);
                    end
                    n_reserve = limit;
                end
            end
        end
    end

    // Configuration, counters and both pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_on    <= 1'b0;
            r_max       <= '0;
            r_res_on    <= 1'b0;
            r_min       <= '0;
            r_used      <= '0;
            r_reserve   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Input register takes a new item when there is room.
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end

            // Output register and counter update.
            if (advance) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_used    <= n_used;
                    r_reserve <= n_reserve;
                end
            end

            // Configuration writes must arrive only while the block is idle; the block does not enforce this.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_LIMIT_ON:   r_lim_on <= i_cfg_data[0];
                    CFG_MAX_PAGES:      r_max    <= cfg_val;
                    CFG_MIN_RESERVE_ON: r_res_on <= i_cfg_data[0];
                    CFG_MIN_PAGES: begin
                        r_min     <= cfg_val;
                        r_used    <= '0;
                        r_reserve <= cfg_val;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_s1_action <= i_req.action;
            r_s1_delta  <= req_delta;
        end
        if (advance && r_s1_valid) begin
            r_status   <= n_status;
            r_charge   <= FIELD_BITS'(WX'(n_charge));
            r_used_out <= FIELD_BITS'(WX'(n_used));
            r_res_out  <= FIELD_BITS'(WX'(n_reserve));
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.pages_to_charge = r_charge;
    assign o_rsp.used_now        = r_used_out;
    assign o_rsp.reserve_now     = r_res_out;

endmodule

>>> dv/page_quota_reserve_accounting_tb.sv
// Self-checking testbench for the pool page quota accountant: directed and random request traffic.
module page_quota_reserve_accounting_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pqra_pkg::*;

    localparam logic [FIELD_BITS-1:0] ALL_ONES = '1;
    // Cycles in which no item moves on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 500;

    typedef struct packed {
        logic                  status;
        logic [FIELD_BITS-1:0] charge;
        logic [FIELD_BITS-1:0] used;
        logic [FIELD_BITS-1:0] reserve;
    } t_page_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [FIELD_BITS-1:0] cfg_data;

    pqra_req_if req_ch ();
    pqra_rsp_if rsp_ch ();

    page_quota_reserve_accounting u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Shadow copy of the pool registers and counters.
    logic                  mdl_limit_on;
    logic [FIELD_BITS-1:0] mdl_max;
    logic                  mdl_reserve_on;
    logic [FIELD_BITS-1:0] mdl_min;
    logic [FIELD_BITS-1:0] mdl_used;
    logic [FIELD_BITS-1:0] mdl_reserve;

    t_page_result pending_results[$];
    t_page_result got_result;
    t_page_result want_result;
    int           error_count;
    int           snd_idle_pct;
    int           rcv_stall_pct;
    int           quiet_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Adds two counts, saturating at the largest count.
    function automatic logic [FIELD_BITS-1:0] sat_sum(logic [FIELD_BITS-1:0] a,
                                                      logic [FIELD_BITS-1:0] b);
        logic [FIELD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[FIELD_BITS] ? ALL_ONES : sum[FIELD_BITS-1:0];
    endfunction

    // Applies one take or return to the shadow state and returns the expected result.
    function automatic t_page_result account_pages(logic act, logic [FIELD_BITS-1:0] cnt);
        t_page_result          res;
        logic [FIELD_BITS-1:0] room;
        res.status = STAT_DONE;
        res.charge = cnt;
        if (act == ACT_TAKE) begin
            if (mdl_limit_on && (mdl_used > mdl_max || cnt > mdl_max - mdl_used)) begin
                res.status = STAT_REFUSED;
                res.charge = '0;
            end else begin
                mdl_used = sat_sum(mdl_used, cnt);
                if (mdl_reserve_on && mdl_reserve != '0) begin
                    if (cnt > mdl_reserve) begin
                        res.charge  = cnt - mdl_reserve;
                        mdl_reserve = '0;
                    end else begin
                        res.charge  = '0;
                        mdl_reserve = mdl_reserve - cnt;
                    end
                end
            end
        end else begin
            mdl_used = (cnt > mdl_used) ? '0 : mdl_used - cnt;
            if (mdl_reserve_on && mdl_used < mdl_min) begin
                room = mdl_min - mdl_used;
                if (mdl_reserve <= room && cnt <= room - mdl_reserve) begin
                    res.charge  = '0;
                    mdl_reserve = mdl_reserve + cnt;
                end else begin
                    if (mdl_reserve >= room) begin
                        res.charge = sat_sum(mdl_reserve - room, cnt);
                    end else begin
                        res.charge = cnt - (room - mdl_reserve);
                    end
                    mdl_reserve = room;
                end
            end
        end
        res.used    = mdl_used;
        res.reserve = mdl_reserve;
        return res;
    endfunction

    function automatic void check_field(string label, logic [FIELD_BITS-1:0] want,
                                        logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t mismatch on %s: expected %h, actual %h", $time, label, want, got);
            error_count++;
        end
    endfunction

    // Result checker and receiver stall generation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_result = '{rsp_ch.status, rsp_ch.pages_to_charge, rsp_ch.used_now,
                           rsp_ch.reserve_now};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got_result);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("status", want_result.status, got_result.status);
                check_field("pages_to_charge", want_result.charge, got_result.charge);
                check_field("used_now", want_result.used, got_result.used);
                check_field("reserve_now", want_result.reserve, got_result.reserve);
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one item, records its expected result, then idles at random.
    task automatic send_request(logic act, logic [FIELD_BITS-1:0] cnt);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.page_count <= cnt;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(account_pages(act, cnt));
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            req_ch.valid      <= 1'b0;
            req_ch.action     <= 1'($urandom_range(1));
            req_ch.page_count <= $urandom;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes one register once the block is idle and mirrors it in the shadow state.
    task automatic write_register(t_cfg_idx idx, logic [FIELD_BITS-1:0] val);
        wait_all_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_LIMIT_ON:   mdl_limit_on = val[0];
            CFG_MAX_PAGES:      mdl_max = val;
            CFG_MIN_RESERVE_ON: mdl_reserve_on = val[0];
            CFG_MIN_PAGES: begin
                mdl_min     = val;
                mdl_used    = '0;
                mdl_reserve = val;
            end
            default: ;
        endcase
    endtask

    // Picks a bound value: extremes, small and medium pools, and anything.
    function automatic logic [FIELD_BITS-1:0] pick_bound();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return $urandom_range(500, 1);
            4:       return $urandom_range(100000, 500);
            default: return $urandom;
        endcase
    endfunction

    // Picks a page count, biased toward sizes that interact with the limit and reserve.
    function automatic logic [FIELD_BITS-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return $urandom_range(40);
        if (roll < 70) return $urandom_range(400);
        if (roll < 78) return $urandom;
        if (roll < 82) return ALL_ONES;
        if (roll < 86) return '0;
        if (roll < 93) return mdl_max - mdl_used;
        return mdl_max - mdl_used + 1;
    endfunction

    task automatic randomize_config();
        write_register(CFG_MAX_LIMIT_ON, $urandom);
        write_register(CFG_MAX_PAGES, pick_bound());
        write_register(CFG_MIN_RESERVE_ON, $urandom);
        if ($urandom_range(3) != 0) write_register(CFG_MIN_PAGES, pick_bound());
    endtask

    task automatic random_request();
        send_request(($urandom_range(99) < 55) ? ACT_TAKE : ACT_RETURN, pick_count());
    endtask

    // With every register at reset: no limit, no reserve, saturating used count.
    task automatic test_reset_defaults();
        send_request(ACT_TAKE, '0);
        send_request(ACT_TAKE, 32'h1234_5678);
        send_request(ACT_TAKE, ALL_ONES);
        send_request(ACT_RETURN, 32'd5);
        send_request(ACT_RETURN, ALL_ONES);
        send_request(ACT_TAKE, 32'hAAAA_AAAA);
        send_request(ACT_RETURN, 32'h5555_5555);
    endtask

    // Maximum limit: exact fit, refusal, used above a lowered maximum, both extremes.
    task automatic test_max_limit();
        write_register(CFG_MAX_PAGES, 32'd100);
        write_register(CFG_MAX_LIMIT_ON, 32'd1);
        write_register(CFG_MIN_PAGES, '0);
        send_request(ACT_TAKE, 32'd60);
        send_request(ACT_TAKE, 32'd40);
        send_request(ACT_TAKE, 32'd1);
        send_request(ACT_RETURN, 32'd200);
        send_request(ACT_TAKE, 32'd101);
        send_request(ACT_TAKE, 32'd50);
        write_register(CFG_MAX_PAGES, 32'd10);
        send_request(ACT_TAKE, '0);
        write_register(CFG_MAX_PAGES, '0);
        write_register(CFG_MIN_PAGES, '0);
        send_request(ACT_TAKE, '0);
        send_request(ACT_TAKE, 32'd1);
        write_register(CFG_MAX_PAGES, ALL_ONES);
        send_request(ACT_TAKE, ALL_ONES);
        send_request(ACT_TAKE, 32'd1);
        write_register(CFG_MAX_LIMIT_ON, '0);
    endtask

    // Minimum reserve: draw, empty reserve, refill, excess, reserve above room, reserve off.
    task automatic test_min_reserve();
        write_register(CFG_MIN_RESERVE_ON, 32'd1);
        write_register(CFG_MIN_PAGES, 32'd50);
        send_request(ACT_TAKE, 32'd20);
        send_request(ACT_TAKE, 32'd40);
        send_request(ACT_TAKE, 32'd5);
        send_request(ACT_RETURN, 32'd30);
        send_request(ACT_RETURN, 32'd100);
        // Used count at or above the minimum leaves the reserve alone on a return.
        send_request(ACT_TAKE, 32'd80);
        send_request(ACT_RETURN, 32'd5);
        // Reserve larger than the room left below the minimum.
        write_register(CFG_MIN_RESERVE_ON, '0);
        write_register(CFG_MIN_PAGES, 32'd50);
        send_request(ACT_TAKE, 32'd40);
        write_register(CFG_MIN_RESERVE_ON, 32'd1);
        send_request(ACT_RETURN, 32'd5);
        // Largest minimum, then a return of the largest count.
        write_register(CFG_MIN_RESERVE_ON, '0);
        write_register(CFG_MIN_PAGES, ALL_ONES);
        send_request(ACT_TAKE, 32'd7);
        write_register(CFG_MIN_RESERVE_ON, 32'd1);
        send_request(ACT_RETURN, ALL_ONES);
        write_register(CFG_MIN_RESERVE_ON, '0);
        send_request(ACT_RETURN, 32'd3);
    endtask

    // A burst against a stalling receiver, a full drain, then more traffic.
    task automatic test_drain_pause();
        rcv_stall_pct = 80;
        repeat (30) random_request();
        wait_all_results();
        rcv_stall_pct = 0;
        repeat (10) random_request();
    endtask

    // Random traffic in blocks between random register settings, under each idling mix.
    task automatic test_random_traffic();
        int sent;
        int blk;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 80; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 80; end
                default: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                randomize_config();
                blk = $urandom_range(100, 20);
                repeat (blk) random_request();
                sent += blk;
            end
        end
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
    endtask

    // Test sequence.
    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_MAX_LIMIT_ON;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_TAKE;
        req_ch.page_count = '0;
        rsp_ch.ready      = 1'b0;
        snd_idle_pct      = 0;
        rcv_stall_pct     = 0;
        error_count       = 0;
        mdl_limit_on      = 1'b0;
        mdl_max           = '0;
        mdl_reserve_on    = 1'b0;
        mdl_min           = '0;
        mdl_used          = '0;
        mdl_reserve       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_max_limit();
        test_min_reserve();
        test_drain_pause();
        test_random_traffic();

        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t missing results: expected %0d more, actual 0", $time,
                     pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
